@@ rtl/core/chvc_pkg.sv @@
//------------------------------------------------------------------------------
// chvc_pkg
// Shared types and constants for the cache hierarchy with victim cache.
//------------------------------------------------------------------------------
package chvc_pkg;

    localparam int ADDR_W  = 12;
    localparam int TAG_W   = 6;
    localparam int SET_W   = 4;
    localparam int BLK_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int LINE_W  = 32;

    typedef enum logic [1:0] {
        SRV_L1  = 2'd0,
        SRV_VC  = 2'd1,
        SRV_L2  = 2'd2,
        SRV_MEM = 2'd3
    } t_served;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_MEMRD,
        ST_VCPUT,
        ST_L2PUT,
        ST_OUT
    } t_state;

endpackage

@@ rtl/core/cache_hierarchy_with_victim_cache.sv @@
//------------------------------------------------------------------------------
// cache_hierarchy_with_victim_cache
// L1 direct mapped, fully associative LRU victim cache, set-associative LRU L2,
// write-through byte main memory.
//------------------------------------------------------------------------------
// Flow: a word is accepted in IDLE and looked up in LOOK; a hit or a store then goes
// to OUT, a load miss to memory first reads the line byte by byte in MEMRD, and VC
// and L2 insertions pass through VCPUT and L2PUT. Words are taken one at a time, the
// pace set by the single byte-wide main memory port and the eviction chain L1 -> VC -> L2.
// Reset: valid bits clear and ranks reset to way order at once; main memory is swept
// to zero, one byte per cycle over all MEM_D bytes (at most 4096), while no word is accepted.
//------------------------------------------------------------------------------
module cache_hierarchy_with_victim_cache #(
    parameter int VICTIM_WAYS = 4,
    parameter int L2_WAYS     = 8,
    parameter int MEM_BYTES   = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // op[0], address[12:1], store_value[20:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // load_value[7:0], served_by[9:8]
);
    import chvc_pkg::*;

    localparam int VW    = (VICTIM_WAYS > 1) ? $clog2(VICTIM_WAYS) : 1;
    localparam int LW    = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    // only 12 address bits reach memory, so no more than 4096 bytes are kept
    localparam int MEM_D = (MEM_BYTES < 4096) ? MEM_BYTES : 4096;
    localparam int MW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int L2D   = 16 * (2 ** LW);

    t_state r_state, n_state;

    // input word
    logic              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0] r_val;
    wire  [1:0]        w_off = r_addr[1:0];
    wire  [SET_W-1:0]  w_set = r_addr[5:2];
    wire  [TAG_W-1:0]  w_tag = r_addr[11:6];
    wire  [BLK_W-1:0]  w_blk = r_addr[11:2];

    // L1: valid flops, tag/data in flops (16 entries, read at one address)
    logic [15:0]       r_l1_v;
    logic [TAG_W-1:0]  r_l1_tag  [16];
    logic [LINE_W-1:0] r_l1_data [16];

    // victim cache: small, searched in parallel
    logic [VICTIM_WAYS-1:0] r_vc_v;
    logic [BLK_W-1:0]       r_vc_tag  [VICTIM_WAYS];
    logic [LINE_W-1:0]      r_vc_data [VICTIM_WAYS];
    logic [VW-1:0]          r_vc_rank [VICTIM_WAYS];

    // L2: one set row per address in a synchronous memory
    logic [L2D-1:0]                r_l2_v;
    logic [L2_WAYS*TAG_W-1:0]      m_l2_tag  [16];
    logic [L2_WAYS*LINE_W-1:0]     m_l2_data [16];
    logic [L2_WAYS*LW-1:0]         m_l2_rank [16];
    logic [L2_WAYS*TAG_W-1:0]      r_l2q_tag;
    logic [L2_WAYS*LINE_W-1:0]     r_l2q_data;
    logic [L2_WAYS*LW-1:0]         r_l2q_rank;
    logic [15:0]                   r_rank_ok;

    // main memory
    logic [BYTE_W-1:0] m_mem [MEM_D];
    logic [BYTE_W-1:0] r_mem_q;
    logic [MW:0]       r_clr;
    logic [2:0]        r_bcnt;
    logic [LINE_W-1:0] r_fill;

    // result and eviction bookkeeping
    logic [BYTE_W-1:0] r_res_val;
    t_served           r_res_srv;
    logic              r_ev_l1;
    logic [BLK_W-1:0]  r_ev_blk;
    logic [LINE_W-1:0] r_ev_data;
    logic [BLK_W-1:0]  r_ev2_blk;
    logic [LINE_W-1:0] r_ev2_data;
    logic [SET_W-1:0]  r_l2_set;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {6'd0, r_res_srv, r_res_val};

    // ---------------- helpers ----------------
    function automatic logic [BYTE_W-1:0] f_byte(logic [LINE_W-1:0] l, logic [1:0] o);
        return l[o*8 +: 8];
    endfunction
    function automatic logic [LINE_W-1:0] f_put(logic [LINE_W-1:0] l, logic [1:0] o,
                                                 logic [BYTE_W-1:0] b);
        logic [LINE_W-1:0] t;
        t = l;
        t[o*8 +: 8] = b;
        return t;
    endfunction

    // L2 row view, ranks of a never-touched set read as way number
    logic [TAG_W-1:0]  w_l2t [L2_WAYS];
    logic [LINE_W-1:0] w_l2d [L2_WAYS];
    logic [LW-1:0]     w_l2r [L2_WAYS];
    logic [L2_WAYS-1:0] w_l2v;
    always_comb begin
        for (int i = 0; i < L2_WAYS; i++) begin
            w_l2t[i] = r_l2q_tag[i*TAG_W +: TAG_W];
            w_l2d[i] = r_l2q_data[i*LINE_W +: LINE_W];
            w_l2r[i] = r_rank_ok[r_l2_set] ? r_l2q_rank[i*LW +: LW] : LW'(i);
            w_l2v[i] = r_l2_v[{r_l2_set, LW'(i)}];
        end
    end

    // lookups
    logic              w_l1_hit;
    logic              w_vc_hit;
    logic [VW-1:0]     w_vc_w;
    logic              w_l2_hit;
    logic [LW-1:0]     w_l2_w;
    always_comb begin
        w_l1_hit = r_l1_v[w_set] && (r_l1_tag[w_set] == w_tag);
        w_vc_hit = 1'b0;
        w_vc_w   = '0;
        for (int i = VICTIM_WAYS - 1; i >= 0; i--)
            if (r_vc_v[i] && r_vc_tag[i] == w_blk) begin
                w_vc_hit = 1'b1;
                w_vc_w   = VW'(i);
            end
        w_l2_hit = 1'b0;
        w_l2_w   = '0;
        for (int i = L2_WAYS - 1; i >= 0; i--)
            if (w_l2v[i] && w_l2t[i] == w_tag) begin
                w_l2_hit = 1'b1;
                w_l2_w   = LW'(i);
            end
    end

    // victim pick: lowest invalid way, else rank 0
    logic [VW-1:0] w_vc_pick;
    always_comb begin
        w_vc_pick = '0;
        for (int i = 0; i < VICTIM_WAYS; i++)
            if (r_vc_rank[i] == '0) w_vc_pick = VW'(i);
        for (int i = VICTIM_WAYS - 1; i >= 0; i--)
            if (!r_vc_v[i]) w_vc_pick = VW'(i);
    end
    logic [LW-1:0] w_l2_pick;
    always_comb begin
        w_l2_pick = '0;
        for (int i = 0; i < L2_WAYS; i++)
            if (w_l2r[i] == '0) w_l2_pick = LW'(i);
        for (int i = L2_WAYS - 1; i >= 0; i--)
            if (!w_l2v[i]) w_l2_pick = LW'(i);
    end

    // touched L2 rank row for a given way
    function automatic logic [L2_WAYS*LW-1:0] f_l2touch(logic [LW-1:0] w,
                                                         logic [LW-1:0] rk [L2_WAYS]);
        logic [L2_WAYS*LW-1:0] o;
        for (int i = 0; i < L2_WAYS; i++) begin
            if (LW'(i) == w)        o[i*LW +: LW] = LW'(L2_WAYS - 1);
            else if (rk[i] > rk[w]) o[i*LW +: LW] = rk[i] - 1'b1;
            else                    o[i*LW +: LW] = rk[i];
        end
        return o;
    endfunction

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == (MW+1)'(MEM_D - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_LOOK;
            ST_LOOK: begin
                if (r_op || w_l1_hit) n_state = ST_OUT;
                else if (!w_vc_hit && !w_l2_hit) n_state = ST_MEMRD;
                else if (r_l1_v[w_set]) n_state = ST_VCPUT;
                else n_state = ST_OUT;
            end
            ST_MEMRD: if (r_bcnt == 3'd4) n_state = r_ev_l1 ? ST_VCPUT : ST_OUT;
            // a valid victim being replaced spills to L2
            ST_VCPUT: n_state = r_vc_v[w_vc_pick] ? ST_L2PUT : ST_OUT;
            ST_L2PUT: n_state = ST_OUT;
            ST_OUT:   if (m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory address: fill reads in MEMRD, else the word's byte
    logic [ADDR_W-1:0] w_maddr;
    always_comb begin
        if (r_state == ST_MEMRD) w_maddr = {r_addr[11:2], r_bcnt[1:0]};
        else                     w_maddr = r_addr;
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR)
            m_mem[r_clr[MW-1:0]] <= '0;
        else if (r_state == ST_LOOK && r_op && 32'(r_addr) < 32'(MEM_D))
            m_mem[r_addr[MW-1:0]] <= r_val;
        r_mem_q <= (32'(w_maddr) < 32'(MEM_D)) ? m_mem[w_maddr[MW-1:0]] : '0;
    end

    // L2 row read at accept (set known) and in VCPUT for the victim's set; written on store hit or insert
    logic                      w_l2_we;
    logic [L2_WAYS*TAG_W-1:0]  w_l2_wt;
    logic [L2_WAYS*LINE_W-1:0] w_l2_wd;
    logic [L2_WAYS*LW-1:0]     w_l2_wr;
    logic [SET_W-1:0]          w_l2_ws;
    always_comb begin
        w_l2_we = 1'b0;
        w_l2_wt = r_l2q_tag;
        w_l2_wd = r_l2q_data;
        w_l2_wr = '0;
        for (int i = 0; i < L2_WAYS; i++) w_l2_wr[i*LW +: LW] = w_l2r[i];
        w_l2_ws = r_l2_set;
        if (r_state == ST_LOOK && r_op && !w_l1_hit && !w_vc_hit && w_l2_hit) begin
            w_l2_we = 1'b1;
            w_l2_wd[w_l2_w*LINE_W +: LINE_W] = f_put(w_l2d[w_l2_w], w_off, r_val);
            w_l2_wr = f_l2touch(w_l2_w, w_l2r);
        end else if (r_state == ST_L2PUT) begin
            w_l2_we = 1'b1;
            w_l2_wt[w_l2_pick*TAG_W +: TAG_W]   = r_ev2_blk[9:4];
            w_l2_wd[w_l2_pick*LINE_W +: LINE_W] = r_ev2_data;
            w_l2_wr = f_l2touch(w_l2_pick, w_l2r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_l2_we) begin
            m_l2_tag[w_l2_ws]  <= w_l2_wt;
            m_l2_data[w_l2_ws] <= w_l2_wd;
            m_l2_rank[w_l2_ws] <= w_l2_wr;
        end
        if (r_state == ST_IDLE) begin
            r_l2q_tag  <= m_l2_tag[s_axis_tdata[6:3]];
            r_l2q_data <= m_l2_data[s_axis_tdata[6:3]];
            r_l2q_rank <= m_l2_rank[s_axis_tdata[6:3]];
        end else if (r_state == ST_VCPUT) begin
            r_l2q_tag  <= m_l2_tag[r_vc_tag[w_vc_pick][3:0]];
            r_l2q_data <= m_l2_data[r_vc_tag[w_vc_pick][3:0]];
            r_l2q_rank <= m_l2_rank[r_vc_tag[w_vc_pick][3:0]];
        end
    end

    // ---------------- control and small arrays ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_l1_v    <= '0;
            r_vc_v    <= '0;
            r_l2_v    <= '0;
            r_rank_ok <= '0;
            for (int i = 0; i < VICTIM_WAYS; i++) r_vc_rank[i] <= VW'(i);
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_l2_we) r_rank_ok[w_l2_ws] <= 1'b1;
            case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_op     <= s_axis_tdata[0];
                    r_addr   <= s_axis_tdata[12:1];
                    r_val    <= s_axis_tdata[20:13];
                    r_l2_set <= s_axis_tdata[6:3];
                    r_bcnt   <= '0;
                end
                ST_LOOK: begin
                    r_ev_l1   <= r_l1_v[w_set];
                    r_ev_blk  <= {r_l1_tag[w_set], w_set};
                    r_ev_data <= r_l1_data[w_set];
                    if (w_l1_hit) begin
                        r_res_srv <= SRV_L1;
                        if (r_op) begin
                            r_l1_data[w_set] <= f_put(r_l1_data[w_set], w_off, r_val);
                            r_res_val <= '0;
                        end else r_res_val <= f_byte(r_l1_data[w_set], w_off);
                    end else if (w_vc_hit) begin
                        r_res_srv <= SRV_VC;
                        if (r_op) begin
                            r_res_val <= '0;
                            r_vc_data[w_vc_w] <= f_put(r_vc_data[w_vc_w], w_off, r_val);
                            for (int i = 0; i < VICTIM_WAYS; i++)
                                if (VW'(i) != w_vc_w && r_vc_rank[i] > r_vc_rank[w_vc_w])
                                    r_vc_rank[i] <= r_vc_rank[i] - 1'b1;
                            r_vc_rank[w_vc_w] <= VW'(VICTIM_WAYS - 1);
                        end else begin
                            r_res_val <= f_byte(r_vc_data[w_vc_w], w_off);
                            r_vc_v[w_vc_w]   <= 1'b0;
                            r_l1_v[w_set]    <= 1'b1;
                            r_l1_tag[w_set]  <= w_tag;
                            r_l1_data[w_set] <= r_vc_data[w_vc_w];
                        end
                    end else if (w_l2_hit) begin
                        r_res_srv <= SRV_L2;
                        if (!r_op) begin
                            r_res_val <= f_byte(w_l2d[w_l2_w], w_off);
                            r_l2_v[{w_set, w_l2_w}] <= 1'b0;
                            r_l1_v[w_set]    <= 1'b1;
                            r_l1_tag[w_set]  <= w_tag;
                            r_l1_data[w_set] <= w_l2d[w_l2_w];
                        end else r_res_val <= '0;
                    end else begin
                        r_res_srv <= SRV_MEM;
                        r_res_val <= '0;
                    end
                end
                ST_MEMRD: begin
                    r_bcnt <= r_bcnt + 1'b1;
                    if (r_bcnt != 3'd0) r_fill[(r_bcnt - 1'b1)*8 +: 8] <= r_mem_q;
                    if (r_bcnt == 3'd0) r_res_val <= r_mem_q;
                    if (r_bcnt == 3'd4) begin
                        r_l1_v[w_set]    <= 1'b1;
                        r_l1_tag[w_set]  <= w_tag;
                        r_l1_data[w_set] <= {r_mem_q, r_fill[23:0]};
                    end
                end
                ST_VCPUT: begin
                    r_ev2_blk  <= r_vc_tag[w_vc_pick];
                    r_ev2_data <= r_vc_data[w_vc_pick];
                    r_l2_set   <= r_vc_tag[w_vc_pick][3:0];
                    r_vc_v[w_vc_pick]    <= 1'b1;
                    r_vc_tag[w_vc_pick]  <= r_ev_blk;
                    r_vc_data[w_vc_pick] <= r_ev_data;
                    for (int i = 0; i < VICTIM_WAYS; i++)
                        if (VW'(i) != w_vc_pick && r_vc_rank[i] > r_vc_rank[w_vc_pick])
                            r_vc_rank[i] <= r_vc_rank[i] - 1'b1;
                    r_vc_rank[w_vc_pick] <= VW'(VICTIM_WAYS - 1);
                end
                ST_L2PUT: r_l2_v[{r_l2_set, w_l2_pick}] <= 1'b1;
                default: ;
            endcase
        end
    end

    // read of the word's own byte at LOOK gives the loaded byte on first MEMRD cycle;
    // r_mem_q then holds the fill byte r_bcnt addressed in the previous MEMRD cycle.

endmodule

@@ rtl/core/chvc_checker.sv @@
//------------------------------------------------------------------------------
// chvc_checker
// Port-level checks for the cache hierarchy.
//------------------------------------------------------------------------------
module chvc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0) else $error("pad bits");
endmodule

bind cache_hierarchy_with_victim_cache chvc_checker u_chvc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

@@ sim/tb_cache_hierarchy_with_victim_cache.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_cache_hierarchy_with_victim_cache
// Self-checking bench: byte loads and stores go in on the slave stream, and a
// cache/memory model predicts each byte and the level that served it. Random
// addresses crowd a few sets so that blocks move L1 -> victim cache -> L2.
//------------------------------------------------------------------------------
module tb_cache_hierarchy_with_victim_cache;
    import chvc_pkg::*;

    localparam int N_RANDOM   = 1330;
    localparam int IDLE_LIMIT = 20000;   // covers the memory sweep after reset
    localparam int VC_WAYS    = 4;
    localparam int L2W        = 8;

    // Predicts served level and byte per word, holds the expected results.
    class cache_scoreboard;
        logic        l1_v[16];
        logic [5:0]  l1_t[16];
        logic [31:0] l1_d[16];
        logic        vc_v[VC_WAYS];
        logic [9:0]  vc_t[VC_WAYS];
        logic [31:0] vc_d[VC_WAYS];
        int          vc_rk[VC_WAYS];
        logic        l2_v[16][L2W];
        logic [5:0]  l2_t[16][L2W];
        logic [31:0] l2_d[16][L2W];
        int          l2_rk[16][L2W];
        logic [7:0]  mem[4096];
        logic [7:0]  exp_byte[$];
        t_served     exp_lvl[$];
        int          n_bad, n_ok;
        int          lvl_seen[4];

        function void clear_all();
            for (int s = 0; s < 16; s++) begin
                l1_v[s] = 0;
                for (int w = 0; w < L2W; w++) begin
                    l2_v[s][w] = 0;
                    l2_rk[s][w] = w;
                end
            end
            for (int w = 0; w < VC_WAYS; w++) begin
                vc_v[w] = 0;
                vc_rk[w] = w;
            end
            for (int a = 0; a < 4096; a++) mem[a] = 8'h00;
            n_bad = 0;
            n_ok = 0;
        endfunction

        function void touch_vc(int w);
            int old;
            old = vc_rk[w];
            for (int i = 0; i < VC_WAYS; i++)
                if (i != w && vc_rk[i] > old) vc_rk[i]--;
            vc_rk[w] = VC_WAYS - 1;
        endfunction

        function void touch_l2(int s, int w);
            int old;
            old = l2_rk[s][w];
            for (int i = 0; i < L2W; i++)
                if (i != w && l2_rk[s][i] > old) l2_rk[s][i]--;
            l2_rk[s][w] = L2W - 1;
        endfunction

        // L2 insertion: first free way, else the LRU way; its old block drops.
        function void l2_insert(logic [9:0] blk, logic [31:0] line);
            int s, w;
            s = blk[3:0];
            w = -1;
            for (int i = 0; i < L2W; i++)
                if (w < 0 && !l2_v[s][i]) w = i;
            if (w < 0) begin
                w = 0;
                for (int i = 0; i < L2W; i++)
                    if (l2_rk[s][i] < l2_rk[s][w]) w = i;
            end
            l2_t[s][w] = blk[9:4];
            l2_d[s][w] = line;
            touch_l2(s, w);
            l2_v[s][w] = 1;
        endfunction

        function void vc_insert(logic [9:0] blk, logic [31:0] line);
            int w;
            logic had;
            logic [9:0] old_blk;
            logic [31:0] old_line;
            w = -1;
            for (int i = 0; i < VC_WAYS; i++)
                if (w < 0 && !vc_v[i]) w = i;
            if (w < 0) begin
                w = 0;
                for (int i = 0; i < VC_WAYS; i++)
                    if (vc_rk[i] < vc_rk[w]) w = i;
            end
            had = vc_v[w];
            old_blk = vc_t[w];
            old_line = vc_d[w];
            vc_t[w] = blk;
            vc_d[w] = line;
            touch_vc(w);
            vc_v[w] = 1;
            if (had) l2_insert(old_blk, old_line);
        endfunction

        function void l1_fill(logic [9:0] blk, logic [31:0] line);
            int s;
            logic had;
            logic [31:0] old_line;
            logic [9:0] old_blk;
            s = blk[3:0];
            had = l1_v[s];
            old_blk = {l1_t[s], blk[3:0]};
            old_line = l1_d[s];
            l1_t[s] = blk[9:4];
            l1_d[s] = line;
            l1_v[s] = 1;
            if (had) vc_insert(old_blk, old_line);
        endfunction

        // Called for every accepted input word.
        function void note_access(logic is_store, logic [11:0] a, logic [7:0] v);
            logic [9:0] blk;
            int s, off;
            logic [5:0] tg;
            logic [7:0] b;
            logic [31:0] line;
            t_served lvl;
            blk = a[11:2];
            s = a[5:2];
            off = a[1:0];
            tg = a[11:6];
            b = 8'h00;
            lvl = SRV_MEM;
            if (l1_v[s] && l1_t[s] == tg) begin
                lvl = SRV_L1;
                if (is_store) l1_d[s][8*off +: 8] = v;
                else b = l1_d[s][8*off +: 8];
            end
            for (int w = 0; w < VC_WAYS; w++) begin
                if (lvl == SRV_MEM && vc_v[w] && vc_t[w] == blk) begin
                    lvl = SRV_VC;
                    if (is_store) begin
                        vc_d[w][8*off +: 8] = v;
                        touch_vc(w);
                    end else begin
                        b = vc_d[w][8*off +: 8];
                        vc_v[w] = 0;        // rank left as it was
                        l1_fill(blk, vc_d[w]);
                    end
                end
            end
            for (int w = 0; w < L2W; w++) begin
                if (lvl == SRV_MEM && l2_v[s][w] && l2_t[s][w] == tg) begin
                    lvl = SRV_L2;
                    if (is_store) begin
                        l2_d[s][w][8*off +: 8] = v;
                        touch_l2(s, w);
                    end else begin
                        b = l2_d[s][w][8*off +: 8];
                        l2_v[s][w] = 0;
                        l1_fill(blk, l2_d[s][w]);
                    end
                end
            end
            if (is_store) begin
                mem[a] = v;             // write-through, no allocate
                b = 8'h00;
            end else if (lvl == SRV_MEM) begin
                b = mem[a];
                for (int i = 0; i < 4; i++) line[8*i +: 8] = mem[{a[11:2], 2'(i)}];
                l1_fill(blk, line);
            end
            exp_byte.push_back(b);
            exp_lvl.push_back(lvl);
        endfunction

        function void check_result(logic [7:0] b, logic [1:0] lvl);
            if (exp_byte.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: unexpected result byte=%02h level=%0d", b, lvl);
                return;
            end
            if (b !== exp_byte[0] || lvl !== exp_lvl[0]) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: expected byte=%02h level=%0d, got byte=%02h level=%0d",
                             exp_byte[0], exp_lvl[0], b, lvl);
            end else begin
                n_ok++;
            end
            lvl_seen[exp_lvl[0]]++;
            void'(exp_byte.pop_front());
            void'(exp_lvl.pop_front());
        endfunction

        function int pending();
            return exp_byte.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // op[0], address[12:1], store_value[20:13]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // load_value[7:0], served_by[9:8]

    cache_scoreboard sb;
    logic  quiet;                 // no idling on either side while set
    int    hold_cycles;           // long receiver hold-off request
    int    idle_cnt;

    cache_hierarchy_with_victim_cache u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: check each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[7:0], m_axis_tdata[9:8]);
    end

    // Receiver readiness: random stalls, plus a long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= 15);
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: cycles with no word accepted on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one word and hold it until accepted; then maybe leave a gap.
    task automatic send_access(logic is_store, logic [11:0] a, logic [7:0] v);
        s_axis_tdata  <= {3'b000, v, a, is_store};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_access(is_store, a, v);
        if (!quiet && $urandom_range(0, 99) < 15) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [11:0] a;
        logic        st;
        sb = new();
        sb.clear_all();
        quiet = 1'b0;
        hold_cycles = 0;
        idle_cnt = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: cold miss, L1 hits, byte extremes, then conflict traffic
        // on set 0 that spills L1 -> victim cache -> L2 and hits each level.
        send_access(1'b0, 12'h000, 8'h00);
        send_access(1'b1, 12'h000, 8'hFF);
        send_access(1'b0, 12'h000, 8'h00);
        send_access(1'b0, 12'h003, 8'h00);
        send_access(1'b0, 12'h040, 8'h00);   // evicts block 0 to victim cache
        send_access(1'b0, 12'h000, 8'h00);   // victim hit
        send_access(1'b1, 12'h041, 8'h5A);   // store hit in victim cache
        for (int t = 2; t < 8; t++)
            send_access(1'b0, {6'(t), 6'h00}, 8'h00);   // overflow into L2
        send_access(1'b0, 12'h041, 8'h00);   // L2 hit carrying the stored byte
        send_access(1'b1, 12'h002, 8'hA5);   // store hit in L2 or victim
        send_access(1'b0, 12'h002, 8'h00);
        send_access(1'b1, 12'hFFF, 8'hFF);   // store miss at top address
        send_access(1'b0, 12'hFFF, 8'h00);
        send_access(1'b0, 12'hFFF, 8'h00);
        send_access(1'b1, 12'hAAA, 8'h55);
        send_access(1'b0, 12'h555, 8'h00);

        // Random: mostly a few crowded sets with a small tag pool, rest anywhere.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 150) begin
                hold_cycles = 300;               // block backs up while we keep sending
            end
            if (n == 500) wait_drained();
            quiet = (n >= 700 && n < 900);
            st = ($urandom_range(0, 99) < 35);
            if ($urandom_range(0, 9) < 7)
                a = {6'($urandom_range(0, 11)), 4'($urandom_range(0, 2)),
                     2'($urandom_range(0, 3))};
            else
                a = 12'($urandom);
            send_access(st, a, 8'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("covered %0d checked words: L1 %0d, victim %0d, L2 %0d, memory %0d",
                 sb.n_ok + sb.n_bad, sb.lvl_seen[0], sb.lvl_seen[1], sb.lvl_seen[2],
                 sb.lvl_seen[3]);
        $display("mismatches: %0d", sb.n_bad);
        if (sb.n_bad == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/chvc_pkg.sv
rtl/core/cache_hierarchy_with_victim_cache.sv
rtl/core/chvc_checker.sv
sim/tb_cache_hierarchy_with_victim_cache.sv
